@@ rtl/gbr_pkg.sv @@
`default_nettype none
package gbr_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int SUM_BITS      = 21;   // 16 x full-scale sample, signed
    localparam int NUM_BITS      = 22;   // biased numerator, always positive
    localparam int REC_BITS      = 22;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 12;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
    localparam logic [FH_BITS-1:0] FH_RESET = 12'd480;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       hstart;
        logic       vstart;
        logic       load;
        logic       last;
        logic [1:0] offs;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_res;
        logic row_end;
        logic emit;
        logic div_done;
        logic out_free;
    } t_sts;

    // 1-4-6-4-1 binomial taps
    function automatic logic [2:0] tap_weight(input logic [2:0] t);
        logic [2:0] w;
        unique case (t)
            3'd0, 3'd4: w = 3'd1;
            3'd1, 3'd3: w = 3'd4;
            3'd2:       w = 3'd6;
            default:    w = 3'd0;
        endcase
        return w;
    endfunction

    // floor(2^21 / w): reciprocal of the divisor 2w scaled by 2^22
    function automatic logic [REC_BITS-1:0] recip(input logic [4:0] w);
        logic [REC_BITS-1:0] m;
        unique case (w)
            5'd1:    m = 22'd2097152;
            5'd2:    m = 22'd1048576;
            5'd3:    m = 22'd699050;
            5'd4:    m = 22'd524288;
            5'd5:    m = 22'd419430;
            5'd6:    m = 22'd349525;
            5'd7:    m = 22'd299593;
            5'd8:    m = 22'd262144;
            5'd9:    m = 22'd233016;
            5'd10:   m = 22'd209715;
            5'd11:   m = 22'd190650;
            5'd12:   m = 22'd174762;
            5'd13:   m = 22'd161319;
            5'd14:   m = 22'd149796;
            5'd15:   m = 22'd139810;
            5'd16:   m = 22'd131072;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gbr_if.sv @@
`default_nettype none
interface gbr_in_if import gbr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gbr_out_if import gbr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample blurred;
    logic    run_last;
    logic    frame_last;
    modport source (output valid, output blurred, output run_last, output frame_last,
                    input ready);
    modport sink   (input valid, input blurred, input run_last, input frame_last,
                    output ready);
endinterface

interface gbr_cfg_if import gbr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/gaussian_blur_5x5_edge_renorm_top.sv @@
`default_nettype none
// 5x5 binomial (1-4-6-4-1) blur for signed 16-bit raster samples, done as a
// horizontal then a vertical pass. Taps that fall outside the frame are dropped
// and each pass divides by the sum of the weights it kept, rounding half up.
// After width*height samples send two padding rows; their values are unused.
// Input (r,c) with r,c >= 2 yields output (r-2,c-2); the last input of such a
// row yields three (columns w-3..w-1). run_last marks the final output of one
// input transaction, frame_last the bottom-right pixel. One input is worked at
// a time; an input in column 0 or 1 is only taken into the window. Any other
// input makes, for each column it completes, two trips through the shared
// 4-stage reciprocal divider (start, then wait for done, for each pass), then
// the load; in the top two rows no result leaves and there is no load. A full
// output register stretches the load, and the output register lets the next
// input transaction start while a result waits.
// Configuration writes (0: frame_width, 1: frame_height) are always ready and
// must only be issued while idle.
module gaussian_blur_5x5_edge_renorm_top
    import gbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gbr_in_if.sink     i_pix,
    gbr_out_if.source  o_pix,
    gbr_cfg_if.sink    i_cfg
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // configuration registers accept a transaction every cycle
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = in_ready;

    gbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gbr_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_sample     (i_pix.sample),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_pix.valid),
        .i_out_ready  (o_pix.ready),
        .o_blurred    (o_pix.blurred),
        .o_run_last   (o_pix.run_last),
        .o_frame_last (o_pix.frame_last)
    );
endmodule
`default_nettype wire

@@ rtl/gbr_div.sv @@
`default_nettype none
module gbr_div
    import gbr_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [SUM_BITS-1:0] i_sum,
    input  wire logic [4:0]                 i_wsum,
    output logic                            o_done,
    output t_sample                         o_quot
);
    // q = floor((2S + W) / 2W); numerator biased by 2W * 2^16 to stay positive,
    // which leaves the low 16 bits of the quotient unchanged.
    logic                    r_v1, r_v2, r_v3;
    logic [NUM_BITS-1:0]     r_num1, r_num2, r_rem;
    logic [REC_BITS-1:0]     r_rec;
    logic [5:0]              r_d1, r_d2, r_d3;
    logic [2*NUM_BITS-1:0]   r_prod;
    logic [NUM_BITS-1:0]     r_q0;
    t_sample                 r_quot;

    logic [5:0]              n_d;
    logic [NUM_BITS-1:0]     n_num;
    logic [NUM_BITS-1:0]     q0;
    logic [NUM_BITS+5:0]     qd;

    assign n_d   = {i_wsum, 1'b0};
    assign n_num = {i_sum, 1'b0} + NUM_BITS'(i_wsum) + (NUM_BITS'(n_d) << 16);
    assign q0    = r_prod[2*NUM_BITS-1:NUM_BITS];
    assign qd    = q0 * r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // quotient estimate and remainder settle in the cycle done is high;
    // the corrected quotient is held from the following cycle on
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num1 <= n_num;
            r_rec  <= recip(i_wsum);
            r_d1   <= n_d;
        end
        r_prod <= r_num1 * r_rec;
        r_num2 <= r_num1;
        r_d2   <= r_d1;
        r_q0   <= q0;
        r_rem  <= r_num2 - qd[NUM_BITS-1:0];
        r_d3   <= r_d2;
        if (r_v3) begin
            r_quot <= (r_rem >= NUM_BITS'(r_d3)) ? SAMPLE_BITS'(r_q0 + 1'b1)
                                                 : SAMPLE_BITS'(r_q0);
        end
    end

    assign o_done = r_v3;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

@@ rtl/gbr_ctrl.sv @@
`default_nettype none
module gbr_ctrl
    import gbr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HSTART = 3'd1;
    localparam logic [2:0] ST_HWAIT  = 3'd2;
    localparam logic [2:0] ST_VSTART = 3'd3;
    localparam logic [2:0] ST_VWAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_offs, n_offs;
    logic       is_last;

    assign is_last = (r_offs == (i_sts.row_end ? 2'd2 : 2'd0));

    always_comb begin
        n_state      = r_state;
        n_offs       = r_offs;
        o_cmd        = '0;
        o_cmd.offs   = r_offs;
        o_cmd.last   = is_last;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_offs       = 2'd0;
                    if (i_sts.has_res) n_state = ST_HSTART;
                end
            end
            ST_HSTART: begin
                o_cmd.hstart = 1'b1;
                n_state      = ST_HWAIT;
            end
            ST_HWAIT: begin
                if (i_sts.div_done) n_state = ST_VSTART;
            end
            ST_VSTART: begin
                o_cmd.vstart = 1'b1;
                n_state      = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.emit) begin
                        n_state = ST_EMIT;
                    end else if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_offs  = r_offs + 2'd1;
                        n_state = ST_HSTART;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_offs  = r_offs + 2'd1;
                        n_state = ST_HSTART;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_offs  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_offs  <= n_offs;
        end
    end
endmodule
`default_nettype wire

@@ rtl/gbr_dp.sv @@
`default_nettype none
module gbr_dp
    import gbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire t_sample                  i_sample,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_sample                       o_blurred,
    output logic                          o_run_last,
    output logic                          o_frame_last
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [FW_BITS-1:0] r_frame_width;
    logic [FH_BITS-1:0] r_frame_height;
    logic [CW-1:0]      r_col, r_c;
    logic [RW-1:0]      r_row, r_r, r_hp1;
    logic               r_row_end;
    t_sample            r_win [5];
    t_sample            r_bq  [4];
    logic               r_out_valid;
    t_sample            r_blurred;
    logic               r_run_last, r_frame_last;

    logic [31:0]        fw, fh;
    logic [CW-1:0]      w_last, c_now;
    logic [RW-1:0]      h_use, h_p1, r_now;
    logic               row_end_now;
    logic [CW-1:0]      x;
    logic [1:0]         wsel;

    logic signed [SUM_BITS-1:0] h_sum, v_sum, d_sum;
    logic [4:0]                 h_w, v_w, d_w;
    logic                       div_done;
    t_sample                    div_q;

    // frame geometry in use, clamped to the supported range
    always_comb begin
        fw     = 32'(r_frame_width);
        fh     = 32'(r_frame_height);
        w_last = (fw < 32'd3) ? CW'(2) :
                 (fw > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(fw - 32'd1);
        h_use  = (fh < 32'd3) ? RW'(3) :
                 (fh > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(fh);
        h_p1   = RW'(32'(h_use) + 32'd1);
        c_now  = (r_col > w_last) ? w_last : r_col;
        r_now  = (r_row > h_p1) ? h_p1 : r_row;
        row_end_now = (c_now == w_last);
    end

    assign x    = CW'(32'(r_c) + 32'(i_cmd.offs) - 32'd2);
    assign wsel = r_r[1:0];

    // horizontal pass: window holds columns c-4..c
    always_comb begin
        logic [2:0] idx;
        logic       keep;
        h_sum = '0;
        h_w   = '0;
        for (int t = 0; t < 5; t++) begin
            idx  = 3'(t) + 3'(i_cmd.offs);
            keep = (idx <= 3'd4) && (32'(r_c) + 32'(i_cmd.offs) + 32'(t) >= 32'd4);
            if (keep) begin
                h_sum = h_sum + SUM_BITS'(r_win[idx]) *
                        $signed({2'b00, tap_weight(3'(t))});
                h_w   = h_w + 5'(tap_weight(3'(t)));
            end
        end
    end

    // vertical pass: four stored rows plus the fresh horizontal value
    always_comb begin
        t_sample v;
        logic    keep;
        v_sum = '0;
        v_w   = '0;
        for (int t = 0; t < 5; t++) begin
            v    = (t < 4) ? r_bq[2'(wsel + 2'(t))] : div_q;
            keep = (32'(r_r) + 32'(t) >= 32'd4) &&
                   (32'(r_r) + 32'(t) <= 32'(r_hp1) + 32'd2);
            if (keep) begin
                v_sum = v_sum + SUM_BITS'(v) * $signed({2'b00, tap_weight(3'(t))});
                v_w   = v_w + 5'(tap_weight(3'(t)));
            end
        end
    end

    assign d_sum = i_cmd.vstart ? v_sum : h_sum;
    assign d_w   = i_cmd.vstart ? v_w : h_w;

    gbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hstart | i_cmd.vstart),
        .i_sum   (d_sum),
        .i_wsum  (d_w),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // four row stores, one per line, read together at column x
    for (genvar b = 0; b < 4; b++) begin : g_bank
        t_sample r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (i_cmd.vstart && wsel == 2'(b)) r_mem[x] <= div_q;
            if (i_cmd.hstart) r_bq[b] <= r_mem[x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < 5; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                for (int k = 0; k < 4; k++) r_win[k] <= r_win[k+1];
                r_win[4] <= i_sample;
                if (row_end_now) begin
                    r_col <= '0;
                    r_row <= (r_now == h_p1) ? '0 : RW'(32'(r_now) + 32'd1);
                end else begin
                    r_col <= CW'(32'(c_now) + 32'd1);
                end
            end
            if (i_cmd.load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c       <= c_now;
            r_r       <= r_now;
            r_hp1     <= h_p1;
            r_row_end <= row_end_now;
        end
        if (i_cmd.load) begin
            r_blurred    <= div_q;
            r_run_last   <= i_cmd.last;
            r_frame_last <= r_row_end && (i_cmd.offs == 2'd2) && (r_r == r_hp1);
        end
    end

    always_comb begin
        o_sts.has_res  = (32'(c_now) >= 32'd2);
        o_sts.row_end  = r_row_end;
        o_sts.emit     = (32'(r_r) >= 32'd2);
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_blurred    = r_blurred;
    assign o_run_last   = r_run_last;
    assign o_frame_last = r_frame_last;
endmodule
`default_nettype wire

@@ rtl/gbr_chk.sv @@
`default_nettype none
module gbr_chk
    import gbr_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_out_valid,
    input wire logic    i_out_ready,
    input wire t_sample i_blurred,
    input wire logic    i_run_last,
    input wire logic    i_frame_last,
    input wire logic    i_in_valid,
    input wire logic    i_in_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_blurred) && $stable(i_run_last))
        else $error("stalled output payload changed");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_last |-> i_run_last)
        else $error("frame end not on last result of its input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");
endmodule

bind gaussian_blur_5x5_edge_renorm_top gbr_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_blurred    (o_pix.blurred),
    .i_run_last   (o_pix.run_last),
    .i_frame_last (o_pix.frame_last),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready)
);
`default_nettype wire

@@ tb/gaussian_blur_5x5_edge_renorm_top_test.sv @@
`timescale 1ns / 1ps

module gaussian_blur_5x5_edge_renorm_top_test;
    import gbr_pkg::*;

    localparam int  MAX_W      = 1024;
    localparam int  MAX_H      = 2048;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  SETTLE     = 32;    // enough for a result-less transaction plus divider
    localparam int  IDLE_PCT   = 7;

    typedef struct {
        t_sample blurred;
        logic    run_last;
        logic    frame_last;
    } blur_result_t;

    logic i_clk;
    logic i_rst_n;

    gbr_in_if  pix_in ();
    gbr_out_if pix_out ();
    gbr_cfg_if cfg_bus ();

    gaussian_blur_5x5_edge_renorm_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg_bus)
    );

    // Predictor state: own copy of registers, line stores, window and counters
    logic [FW_BITS-1:0] width_reg;
    logic [FH_BITS-1:0] height_reg;
    int                 line_mem [4*MAX_W];
    int                 win [5];
    int unsigned        col_pos;
    int unsigned        row_pos;
    int                 binom [5] = '{1, 4, 6, 4, 1};

    blur_result_t pending_blur [$];

    int  error_count;
    int  samples_sent;
    int  results_seen;
    int  frames_sent;
    int  cycle_count;
    bit  steady_run;     // no idling on either side while set
    int  hold_request;   // long receiver hold-off, picked up by the receiver process
    int  hold_left;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_blur.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // Output checker: every output transaction against the oldest prediction
    always @(posedge i_clk) begin
        blur_result_t want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pending_blur.size() == 0) begin
                report("unexpected result", pix_out.blurred, 0);
            end else begin
                want = pending_blur.pop_front();
                if (pix_out.blurred !== want.blurred)
                    report("blurred", pix_out.blurred, want.blurred);
                if (pix_out.run_last !== want.run_last)
                    report("run_last", pix_out.run_last, want.run_last);
                if (pix_out.frame_last !== want.frame_last)
                    report("frame_last", pix_out.frame_last, want.frame_last);
            end
            results_seen++;
        end
    end

    // Divide by kept weight, round to nearest with halves up
    function automatic int round_half_up(input longint sum, input longint wsum);
        longint num;
        longint den;
        longint q;
        num = 2 * sum + wsum;
        den = 2 * wsum;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return int'(q);
    endfunction

    // Horizontal pass at column x; window holds columns c-4..c
    function automatic int horiz_blur(input int x, input int c, input int w);
        longint sum;
        longint wsum;
        int     j;
        int     k;
        sum = 0;
        wsum = 0;
        for (int t = 0; t < 5; t++) begin
            j = x - 2 + t;
            k = j - (c - 4);
            if (j >= 0 && j < w && k >= 0 && k <= 4) begin
                sum += binom[t] * win[k];
                wsum += binom[t];
            end
        end
        if (wsum == 0)
            return 0;
        return round_half_up(sum, wsum);
    endfunction

    // Vertical pass at column x for row r; stores the new horizontal value
    function automatic int vert_blur(input int x, input int r, input int h, input int cur);
        longint sum;
        longint wsum;
        int     yy;
        int     v;
        sum = 0;
        wsum = 0;
        for (int t = 0; t < 5; t++) begin
            yy = r - 4 + t;
            v = (t < 4) ? line_mem[((r + t) & 3) * MAX_W + x] : cur;
            if (yy >= 0 && yy < h) begin
                sum += binom[t] * v;
                wsum += binom[t];
            end
        end
        line_mem[(r & 3) * MAX_W + x] = cur;
        if (wsum == 0)
            return 0;
        return round_half_up(sum, wsum);
    endfunction

    // Works out the results one accepted sample causes
    function automatic void predict_blur(input t_sample s);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int           xs [3];
        int           nx;
        bit           row_end;
        int           hv;
        int           vv;
        blur_result_t res;
        blur_result_t burst [$];
        w = (width_reg < 3) ? 3 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg < 3) ? 3 : ((height_reg > MAX_H) ? MAX_H : height_reg);
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        r = (row_pos > h + 1) ? h + 1 : row_pos;
        row_end = (c == w - 1);
        nx = 0;
        for (int i = 0; i < 4; i++)
            win[i] = win[i + 1];
        win[4] = s;
        if (c >= 2) begin
            xs[nx] = c - 2;
            nx++;
        end
        if (row_end) begin
            xs[nx] = c - 1;
            xs[nx + 1] = c;
            nx += 2;
        end
        for (int i = 0; i < nx; i++) begin
            hv = horiz_blur(xs[i], c, w);
            vv = vert_blur(xs[i], r, h, hv);
            if (r >= 2) begin
                res.blurred = t_sample'(vv);
                res.run_last = 1'b0;
                res.frame_last = (r == h + 1 && xs[i] == w - 1);
                burst.push_back(res);
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i])
            pending_blur.push_back(burst[i]);
        if (row_end) begin
            col_pos = 0;
            row_pos = (r >= h + 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // One input transaction; valid stays up so back-to-back samples need no gap
    task automatic send_sample(input t_sample s);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.sample <= s;
        do @(posedge i_clk); while (!pix_in.ready);
        predict_blur(s);
        samples_sent++;
    endtask

    // Mostly full-range noise, with a fair share of the extremes
    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return t_sample'($urandom_range(3)) - 16'sd1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_run(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample());
    endtask

    // Sender goes quiet until every predicted result is out, then lets the block settle
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_blur.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val[CFG_DATA_BITS-1:0];
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == REG_FRAME_WIDTH)
            width_reg = val[FW_BITS-1:0];
        else
            height_reg = val[FH_BITS-1:0];
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Whole frame including the two padding rows
    task automatic send_frame(input int w, input int h);
        send_run(w * (h + 2));
        frames_sent++;
    endtask

    // Smallest frame with saturated content; width below range clamps to 3
    task automatic test_small_extremes();
        set_frame(1, 3);
        for (int i = 0; i < 15; i++)
            send_sample(16'sh7FFF);
        for (int i = 0; i < 15; i++)
            send_sample((i % 2) ? 16'sh8000 : 16'sh7FFF);
        frames_sent += 2;
        wait_drained();
    endtask

    // Width shrunk mid-row, then height shrunk mid-frame (0 clamps to 3)
    task automatic test_shrink_midstream();
        set_frame(8, 4095);
        send_run(16 + 6);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 4);
        send_sample(16'sh8000);       // column clamps, row ends with three results
        send_run(8);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 0);
        send_run(4);                  // lone padding row closes the frame
        frames_sent++;
        wait_drained();
    endtask

    // Width above range clamps to the widest line: one full row at that width,
    // then the rest of the frame on a narrow line
    task automatic test_widest_line();
        set_frame(2047, 3);
        send_run(MAX_W);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 3);
        send_run(4 * 3);
        frames_sent++;
        wait_drained();
    endtask

    // Receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        set_frame(16, 6);
        hold_request = 400;
        send_frame(16, 6);
        wait_drained();
    endtask

    // Random frame shapes, mostly small, sometimes back-to-back without reprogramming
    task automatic test_random_frames();
        int start;
        int w;
        int h;
        int n;
        start = samples_sent;
        w = 5;
        h = 4;
        n = 0;
        while (samples_sent - start < 350) begin
            if (n == 0 || $urandom_range(3) != 0) begin
                wait_drained();
                w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
                h = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(3, 6);
                set_frame(w, h);
            end
            steady_run = (n >= 2 && n <= 4);
            send_frame(w, h);
            n++;
            if ($urandom_range(2) == 0)
                wait_drained();
        end
        steady_run = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        pix_in.valid   <= 1'b0;
        pix_in.sample  <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= REG_FRAME_WIDTH;
        cfg_bus.data   <= '0;
        width_reg      = FW_RESET;
        height_reg     = FH_RESET;
        foreach (line_mem[i])
            line_mem[i] = 0;
        foreach (win[i])
            win[i] = 0;
        col_pos        = 0;
        row_pos        = 0;
        error_count    = 0;
        samples_sent   = 0;
        results_seen   = 0;
        frames_sent    = 0;
        cycle_count    = 0;
        steady_run     = 1'b0;
        hold_request   = 0;
        hold_left      = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_extremes();
        test_shrink_midstream();
        test_widest_line();
        test_backpressure();
        test_random_frames();

        $display("covered %0d frames, %0d samples in, %0d blurred pixels checked",
                 frames_sent, samples_sent, results_seen);
        $display("incl. edge clamping, mid-row and mid-frame shrink, long output stall");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
